// File: rtl/lifo_stack_engine_unit_macros.svh
// ----------------------------------------------------------------------------
// lifo_stack_engine_unit_macros
// Assertion shorthands for the LIFO stack engine, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_ENGINE_UNIT_MACROS_SVH
`define LIFO_STACK_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants of the LIFO stack engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

	localparam int CMD_W    = 4;
	localparam int DATA_W   = 32;
	localparam int CNT_W    = 7;
	localparam int FILL_W   = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 4'd0,
		CMD_POP    = 4'd1,
		CMD_TOP    = 4'd2,
		CMD_DUMP   = 4'd3,
		CMD_CLEAR  = 4'd4,
		CMD_BASE   = 4'd5,
		CMD_SIZE   = 4'd6,
		CMD_POPN   = 4'd7,
		CMD_SUBTOP = 4'd8
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_BADCOUNT = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE  = 1'b0,
		S_MULTI = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // take the request word and apply it
		logic step;    // emit one word of a dump or pop N
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic load_ok;      // result stage can take a new entry
		logic multi_start;  // decoded request runs as a multi-word sequence
		logic last_step;    // one word left in the sequence
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/lse_req_if.sv
// ----------------------------------------------------------------------------
// lse_req_if
// Request channel of the LIFO stack engine: command, push word, pop count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lse_req_if;
	logic                              valid;
	logic                              ready;
	logic [lse_pkg::CMD_W-1:0]         cmd;
	logic signed [lse_pkg::DATA_W-1:0] push_data;
	logic [lse_pkg::CNT_W-1:0]         pop_count;

	modport source (output valid, output cmd, output push_data, output pop_count,
		input ready);
	modport sink (input valid, input cmd, input push_data, input pop_count,
		output ready);
endinterface

`default_nettype wire

// File: rtl/lse_rsp_if.sv
// ----------------------------------------------------------------------------
// lse_rsp_if
// Response channel of the LIFO stack engine: status, word, fill, last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lse_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [lse_pkg::STATUS_W-1:0]      status;
	logic signed [lse_pkg::DATA_W-1:0] value;
	logic [lse_pkg::FILL_W-1:0]        fill;
	logic                              last;

	modport source (output valid, output status, output value, output fill,
		output last, input ready);
	modport sink (input valid, input status, input value, input fill,
		input last, output ready);
endinterface

`default_nettype wire

// File: rtl/lifo_stack_engine_unit.sv
// Result path: a result word passes the result stage, which holds the
//   registered store read, and then the output register.
// Single-word commands (push, pop, top, clear, base, size, sub-top, pop N
//   of zero, errors of dump and pop N) go back to back while rsp is ready.
// Dump and pop N: after the accept, the words leave one at a time through
//   the single read port of the stack store; req.ready stays low meanwhile.
// Reset: fill count cleared, pipeline empty; store contents undefined.
// ----------------------------------------------------------------------------
// lifo_stack_engine_unit
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, dump,
// clear, base, size, pop N and sub-top commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lifo_stack_engine_unit_macros.svh"

module lifo_stack_engine_unit #(
	parameter int DEPTH = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lse_req_if.sink   req,
	lse_rsp_if.source rsp
);

	localparam int FW = $clog2(DEPTH + 1);

	lse_pkg::ctl_cmd_t ctl;
	lse_pkg::dp_stat_t stat;
	logic [FW-1:0]     level;
	logic              rsp_err, rsp_full;

	lse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	lse_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (req.cmd),
		.push_data  (req.push_data),
		.pop_count  (req.pop_count),
		.ctl        (ctl),
		.stat       (stat),
		.level      (level),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_value  (rsp.value),
		.rsp_fill   (rsp.fill),
		.rsp_last   (rsp.last)
	);

	assign rsp_err  = rsp.valid && (rsp.status != lse_pkg::ST_OK);
	assign rsp_full = rsp.valid && (rsp.status == lse_pkg::ST_FULL);

	`LSE_ASSERT_NOW(a_level_bound, 1'b1, level <= FW'(DEPTH), "fill count above depth")
	`LSE_ASSERT_NOW(a_err_single, rsp_err, rsp.last && rsp.value == '0, "bad error word")
	`LSE_ASSERT_NOW(a_full_fill, rsp_full, rsp.fill == lse_pkg::FILL_W'(DEPTH), "full, bad fill")
	`LSE_ASSERT_NEXT(a_multi_block, ctl.accept && stat.multi_start, !req.ready, "ready in sequence")

endmodule

`default_nettype wire

// File: rtl/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl
// Sequencer: takes commands while the result stage has room and walks
// dump / pop N one word per cycle, stalling while the result stage has no room.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire lse_pkg::dp_stat_t stat,
	output lse_pkg::ctl_cmd_t      ctl
);

	lse_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lse_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			lse_pkg::S_IDLE: begin
				in_ready   = stat.load_ok;
				ctl.accept = in_valid && stat.load_ok;
				if (ctl.accept && stat.multi_start) begin
					state_d = lse_pkg::S_MULTI;
				end
			end
			lse_pkg::S_MULTI: begin
				ctl.step = stat.load_ok;
				if (ctl.step && stat.last_step) begin
					state_d = lse_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lse_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/lse_datapath.sv
// ----------------------------------------------------------------------------
// lse_datapath
// Stack store, fill count, command decode, multi-word walk pointer, result
// stage with registered store read, and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lse_datapath #(
	parameter int DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic [lse_pkg::CMD_W-1:0]         cmd,
	input  wire logic signed [lse_pkg::DATA_W-1:0] push_data,
	input  wire logic [lse_pkg::CNT_W-1:0]         pop_count,
	input  wire lse_pkg::ctl_cmd_t                 ctl,
	output lse_pkg::dp_stat_t                      stat,
	output logic [$clog2(DEPTH+1)-1:0]             level,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output logic [lse_pkg::STATUS_W-1:0]           rsp_status,
	output logic signed [lse_pkg::DATA_W-1:0]      rsp_value,
	output logic [lse_pkg::FILL_W-1:0]             rsp_fill,
	output logic                                   rsp_last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);
	localparam int CW = (FW > lse_pkg::CNT_W) ? FW : lse_pkg::CNT_W;

	logic signed [lse_pkg::DATA_W-1:0] mem_q [DEPTH];

	logic [FW-1:0] level_q;
	logic [AW-1:0] ptr_q;
	logic [FW-1:0] rem_q;
	logic          pop_mode_q;

	// result stage
	logic                              v_s1;
	lse_pkg::status_t                  status_s1;
	logic                              use_rd_s1;
	logic signed [lse_pkg::DATA_W-1:0] rd_s1;
	logic [lse_pkg::FILL_W-1:0]        fill_s1;
	logic                              last_s1;

	// output register
	logic                              rsp_valid_q;
	lse_pkg::status_t                  rsp_status_q;
	logic signed [lse_pkg::DATA_W-1:0] rsp_value_q;
	logic [lse_pkg::FILL_W-1:0]        rsp_fill_q;
	logic                              rsp_last_q;

	logic             empty, full;
	logic [FW-1:0]    lvl_m1, lvl_m2;
	lse_pkg::status_t dec_status;
	logic             dec_load, dec_rd, dec_wr, dec_multi, dec_pop_mode;
	logic [AW-1:0]    dec_raddr;
	logic [FW-1:0]    dec_level, dec_rem;
	logic             load_s1, adv, rd_en;
	logic [AW-1:0]    raddr;

	assign empty  = (level_q == '0);
	assign full   = (level_q == FW'(DEPTH));
	assign lvl_m1 = level_q - FW'(1);
	assign lvl_m2 = level_q - FW'(2);

	always_comb begin
		dec_status   = lse_pkg::ST_OK;
		dec_load     = 1'b0;
		dec_rd       = 1'b0;
		dec_wr       = 1'b0;
		dec_multi    = 1'b0;
		dec_pop_mode = 1'b0;
		dec_raddr    = lvl_m1[AW-1:0];
		dec_level    = level_q;
		dec_rem      = level_q;
		case (lse_pkg::cmd_t'(cmd))
			lse_pkg::CMD_PUSH: begin
				dec_load = 1'b1;
				if (full) begin
					dec_status = lse_pkg::ST_FULL;
				end else begin
					dec_wr    = 1'b1;
					dec_level = level_q + FW'(1);
				end
			end
			lse_pkg::CMD_POP: begin
				dec_load = 1'b1;
				if (empty) begin
					dec_status = lse_pkg::ST_EMPTY;
				end else begin
					dec_rd    = 1'b1;
					dec_level = lvl_m1;
				end
			end
			lse_pkg::CMD_TOP: begin
				dec_load = 1'b1;
				if (empty) begin
					dec_status = lse_pkg::ST_EMPTY;
				end else begin
					dec_rd = 1'b1;
				end
			end
			lse_pkg::CMD_DUMP: begin
				if (empty) begin
					dec_load   = 1'b1;
					dec_status = lse_pkg::ST_EMPTY;
				end else begin
					dec_multi = 1'b1;
				end
			end
			lse_pkg::CMD_CLEAR: begin
				dec_load  = 1'b1;
				dec_level = '0;
				if (empty) begin
					dec_status = lse_pkg::ST_EMPTY;
				end
			end
			lse_pkg::CMD_BASE: begin
				dec_load  = 1'b1;
				dec_raddr = '0;
				if (empty) begin
					dec_status = lse_pkg::ST_EMPTY;
				end else begin
					dec_rd = 1'b1;
				end
			end
			lse_pkg::CMD_SIZE: begin
				dec_load = 1'b1;
				if (empty) begin
					dec_status = lse_pkg::ST_EMPTY;
				end
			end
			lse_pkg::CMD_POPN: begin
				if (empty) begin
					dec_load   = 1'b1;
					dec_status = lse_pkg::ST_EMPTY;
				end else if (CW'(pop_count) > CW'(level_q)) begin
					dec_load   = 1'b1;
					dec_status = lse_pkg::ST_BADCOUNT;
				end else if (pop_count == '0) begin
					dec_load = 1'b1;
				end else begin
					// count fits: it is no larger than the fill
					dec_multi    = 1'b1;
					dec_pop_mode = 1'b1;
					dec_rem      = FW'(pop_count);
				end
			end
			lse_pkg::CMD_SUBTOP: begin
				dec_load  = 1'b1;
				dec_raddr = lvl_m2[AW-1:0];
				if (level_q < FW'(2)) begin
					dec_status = lse_pkg::ST_EMPTY;
				end else begin
					dec_rd = 1'b1;
				end
			end
			default: begin
				// unused codes: accepted, no result
			end
		endcase
	end

	assign adv     = v_s1 && (!rsp_valid_q || rsp_ready);
	assign load_s1 = (ctl.accept && dec_load) || ctl.step;
	assign rd_en   = (ctl.accept && dec_rd) || ctl.step;
	assign raddr   = ctl.step ? ptr_q : dec_raddr;

	assign stat.load_ok     = !v_s1 || !rsp_valid_q || rsp_ready;
	assign stat.multi_start = dec_multi;
	assign stat.last_step   = (rem_q == FW'(1));

	always_ff @(posedge clk) begin
		if (ctl.accept && dec_wr) begin
			mem_q[level_q[AW-1:0]] <= push_data;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (ctl.accept) begin
			level_q <= dec_level;
		end else if (ctl.step && pop_mode_q) begin
			level_q <= lvl_m1;
		end
	end

	// walk pointer for dump / pop N, starting at the top
	always_ff @(posedge clk) begin
		if (ctl.accept && dec_multi) begin
			ptr_q      <= lvl_m1[AW-1:0];
			rem_q      <= dec_rem;
			pop_mode_q <= dec_pop_mode;
		end else if (ctl.step) begin
			ptr_q <= ptr_q - AW'(1);
			rem_q <= rem_q - FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			status_s1 <= lse_pkg::ST_OK;
			use_rd_s1 <= 1'b1;
			fill_s1   <= pop_mode_q ? lse_pkg::FILL_W'(lvl_m1) : lse_pkg::FILL_W'(level_q);
			last_s1   <= (rem_q == FW'(1));
		end else if (load_s1) begin
			status_s1 <= dec_status;
			use_rd_s1 <= dec_rd;
			fill_s1   <= lse_pkg::FILL_W'(dec_level);
			last_s1   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_status_q <= status_s1;
			rsp_value_q  <= use_rd_s1 ? rd_s1 : '0;
			rsp_fill_q   <= fill_s1;
			rsp_last_q   <= last_s1;
		end
	end

	assign level      = level_q;
	assign rsp_valid  = rsp_valid_q;
	assign rsp_status = rsp_status_q;
	assign rsp_value  = rsp_value_q;
	assign rsp_fill   = rsp_fill_q;
	assign rsp_last   = rsp_last_q;

endmodule

`default_nettype wire

// File: bench/lse_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lse_result_checker
// Watches the request and response channels of the LIFO stack engine. Keeps
// its own copy of the stack, works out the result words each accepted
// command must produce and matches them in order against the response side.
// ----------------------------------------------------------------------------

module lse_result_checker
	import lse_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	lse_req_if          req,
	lse_rsp_if          rsp,
	output int unsigned outstanding,
	output int unsigned error_count
);

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] value;
		logic [FILL_W-1:0] fill;
		logic              last;
	} rsp_word_t;

	logic [DATA_W-1:0] stack_copy [DEPTH];
	int unsigned       level = 0;
	rsp_word_t         pending_words [$];
	int unsigned       queued = 0;
	int unsigned       mismatches = 0;

	assign outstanding = queued;
	assign error_count = mismatches;

	function automatic void post_word(status_t st, logic [DATA_W-1:0] v, logic fin);
		rsp_word_t w;
		w.status = st;
		w.value  = v;
		w.fill   = level[FILL_W-1:0];
		w.last   = fin;
		pending_words.push_back(w);
	endfunction

	task automatic run_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] word,
		input logic [CNT_W-1:0] count);
		int unsigned k;
		case (code)
			CMD_PUSH: begin
				if (level >= DEPTH) begin
					post_word(ST_FULL, '0, 1'b1);
				end else begin
					stack_copy[level] = word;
					level++;
					post_word(ST_OK, '0, 1'b1);
				end
			end
			CMD_POP: begin
				if (level == 0) begin
					post_word(ST_EMPTY, '0, 1'b1);
				end else begin
					level--;
					post_word(ST_OK, stack_copy[level], 1'b1);
				end
			end
			CMD_TOP: begin
				if (level == 0) post_word(ST_EMPTY, '0, 1'b1);
				else post_word(ST_OK, stack_copy[level-1], 1'b1);
			end
			CMD_DUMP: begin
				if (level == 0) begin
					post_word(ST_EMPTY, '0, 1'b1);
				end else begin
					// top first, stack left as is
					for (k = level; k > 0; k--)
						post_word(ST_OK, stack_copy[k-1], k == 1);
				end
			end
			CMD_CLEAR: begin
				if (level == 0) begin
					post_word(ST_EMPTY, '0, 1'b1);
				end else begin
					level = 0;
					post_word(ST_OK, '0, 1'b1);
				end
			end
			CMD_BASE: begin
				if (level == 0) post_word(ST_EMPTY, '0, 1'b1);
				else post_word(ST_OK, stack_copy[0], 1'b1);
			end
			CMD_SIZE: begin
				post_word((level == 0) ? ST_EMPTY : ST_OK, '0, 1'b1);
			end
			CMD_POPN: begin
				if (level == 0) begin
					post_word(ST_EMPTY, '0, 1'b1);
				end else if (count > level) begin
					post_word(ST_BADCOUNT, '0, 1'b1);
				end else if (count == 0) begin
					post_word(ST_OK, '0, 1'b1);
				end else begin
					// fill drops with each word
					for (k = 0; k < count; k++) begin
						level--;
						post_word(ST_OK, stack_copy[level], k + 1 == count);
					end
				end
			end
			CMD_SUBTOP: begin
				if (level < 2) post_word(ST_EMPTY, '0, 1'b1);
				else post_word(ST_OK, stack_copy[level-2], 1'b1);
			end
			default: ;  // unused codes give nothing
		endcase
	endtask

	task automatic match_word();
		rsp_word_t want;
		if (pending_words.size() == 0) begin
			$display("%0t unexpected word: status %0d value %h fill %0d last %0b",
				$time, rsp.status, rsp.value, rsp.fill, rsp.last);
			mismatches++;
		end else begin
			want = pending_words.pop_front();
			if (rsp.status !== want.status || rsp.value !== want.value ||
				rsp.fill !== want.fill || rsp.last !== want.last) begin
				$display("%0t mismatch: expected status %0d value %h fill %0d last %0b,",
					$time, want.status, want.value, want.fill, want.last,
					" actual status %0d value %h fill %0d last %0b",
					rsp.status, rsp.value, rsp.fill, rsp.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			// match first so a word never pairs with a command from this same edge
			if (rsp.valid && rsp.ready) match_word();
			if (req.valid && req.ready) run_command(req.cmd, req.push_data, req.pop_count);
			queued <= pending_words.size();
		end
	end

endmodule

// File: bench/lifo_stack_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lifo_stack_engine_unit_tb
// Drives command words into the LIFO stack engine in random bursts, stalls
// the response side on its own pattern and lets the checker compare every
// result word. Directed corner cases first, then random stack traffic.
// ----------------------------------------------------------------------------

module lifo_stack_engine_unit_tb;
	import lse_pkg::*;

	localparam int          DEPTH         = 64;
	localparam int unsigned RANDOM_ITEMS  = 285;
	localparam int unsigned STALL_LIMIT   = 2000;
	localparam int unsigned TAIL_CYCLES   = 20;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

	logic        clk;
	logic        arst_n;
	int unsigned outstanding;
	int unsigned error_count;

	lse_req_if req ();
	lse_rsp_if rsp ();

	lifo_stack_engine_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lse_result_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.outstanding (outstanding),
		.error_count (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stimulus-side view of the fill, used only to shape the traffic
	int unsigned stack_level = 0;
	int unsigned burst_left  = 0;
	int unsigned lean        = 2;  // 0 grow, 1 shrink, 2 mixed

	task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] word,
		input logic [CNT_W-1:0] count);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			lean = $urandom_range(0, 2);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.cmd       <= code;
		req.push_data <= word;
		req.pop_count <= count;
		do @(posedge clk); while (!req.ready);
		case (code)
			CMD_PUSH:  if (stack_level < DEPTH) stack_level++;
			CMD_POP:   if (stack_level > 0) stack_level--;
			CMD_CLEAR: stack_level = 0;
			CMD_POPN:  if (stack_level > 0 && count <= stack_level) stack_level -= count;
			default: ;
		endcase
	endtask

	// hold the sender until every result word is back
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] pick_count();
		int unsigned q;
		q = $urandom_range(0, 9);
		if (q < 7) return CNT_W'($urandom_range(0, stack_level));
		else if (q < 9) return CNT_W'($urandom_range(0, 127));
		else return CNT_W'(stack_level + 1);
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd();
		int unsigned push_weight;
		push_weight = (lean == 0) ? 70 : (lean == 1) ? 15 : 40;
		if ($urandom_range(0, 99) < push_weight) return CMD_PUSH;
		case ($urandom_range(0, 19))
			0, 1, 2, 3:     return CMD_POP;
			4, 5:           return CMD_TOP;
			6, 7:           return CMD_DUMP;
			8:              return CMD_CLEAR;
			9, 10:          return CMD_BASE;
			11, 12:         return CMD_SIZE;
			13, 14, 15, 16: return CMD_POPN;
			17, 18:         return CMD_SUBTOP;
			default:        return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
		endcase
	endfunction

	initial begin
		logic [CMD_W-1:0] code;
		int unsigned      done_items;
		req.valid     <= 1'b0;
		req.cmd       <= CMD_PUSH;
		req.push_data <= '0;
		req.pop_count <= '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack corners
		send_cmd(CMD_POP,    '0, '0);
		send_cmd(CMD_TOP,    '0, '0);
		send_cmd(CMD_BASE,   '0, '0);
		send_cmd(CMD_SUBTOP, '0, '0);
		send_cmd(CMD_SIZE,   '0, '0);
		send_cmd(CMD_DUMP,   '0, '0);
		send_cmd(CMD_CLEAR,  '0, '0);
		send_cmd(CMD_POPN,   '0, 7'd5);
		send_cmd(CMD_SPARE_LO, '1, '1);
		send_cmd(CMD_SPARE_HI, '1, '1);
		// sub-top with one word, then extreme words
		send_cmd(CMD_PUSH,   32'h8000_0000, '0);
		send_cmd(CMD_SUBTOP, '0, '0);
		send_cmd(CMD_PUSH,   32'h7FFF_FFFF, '0);
		send_cmd(CMD_PUSH,   '0, '0);
		send_cmd(CMD_PUSH,   '1, '0);
		send_cmd(CMD_TOP,    '0, '0);
		send_cmd(CMD_BASE,   '0, '0);
		send_cmd(CMD_SUBTOP, '0, '0);
		send_cmd(CMD_SIZE,   '0, '0);
		send_cmd(CMD_DUMP,   '0, '0);
		send_cmd(CMD_POPN,   '0, 7'd0);
		send_cmd(CMD_POPN,   '0, 7'd127);
		send_cmd(CMD_POPN,   '0, 7'd2);
		send_cmd(CMD_POP,    '0, '0);
		send_cmd(CMD_CLEAR,  '0, '0);
		drain();

		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			if (done_items == 120) begin
				// fill to the brim, bounce off full, then take it all back
				while (stack_level < DEPTH) begin
					send_cmd(CMD_PUSH, pick_word(), '0);
					done_items++;
				end
				repeat (3) send_cmd(CMD_PUSH, pick_word(), '0);
				send_cmd(CMD_DUMP,   '0, '0);
				send_cmd(CMD_SUBTOP, '0, '0);
				send_cmd(CMD_POPN,   '0, CNT_W'(DEPTH));
				send_cmd(CMD_SIZE,   '0, '0);
				done_items += 7;
				drain();
			end
			code = pick_cmd();
			send_cmd(code, pick_word(), pick_count());
			if (code < CMD_SPARE_LO) done_items++;
			if ($urandom_range(0, 49) == 0) drain();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// response side stalls on its own schedule
	initial begin
		int unsigned mode;
		int unsigned span;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 48);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0:       rsp.ready <= 1'b1;
					1:       rsp.ready <= $urandom_range(0, 1);
					2:       rsp.ready <= ($urandom_range(0, 7) != 0);
					default: rsp.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ends the run if no word moves on either channel for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
			else quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: lifo_stack_engine_unit.f
+incdir+rtl
rtl/lse_pkg.sv
rtl/lse_req_if.sv
rtl/lse_rsp_if.sv
rtl/lse_ctrl.sv
rtl/lse_datapath.sv
rtl/lifo_stack_engine_unit.sv
bench/lse_result_checker.sv
bench/lifo_stack_engine_unit_tb.sv
